// File: rtl/array_max_priority_queue_macros.svh
// Assertion macros shared by the priority queue RTL.
`ifndef ARRAY_MAX_PRIORITY_QUEUE_MACROS_SVH
`define ARRAY_MAX_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AMPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define AMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ampq_pkg.sv
// Types, codes and sizing constants of the array max-priority queue.
package ampq_pkg;

    localparam int CAPACITY      = 8;
    localparam int VALUE_BITS    = 16;
    localparam int PRIORITY_BITS = 8;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // Request codes (code three does nothing).
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_PEEK   = 2'd2;
    localparam logic [1:0] REQ_NOP    = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]    value;
        logic [PRIORITY_BITS-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] in_element;
        logic [7:0]  in_priority;
    } cmd_t;

    typedef struct packed {
        logic [15:0] out_element;
        logic [7:0]  out_priority;
        logic [1:0]  status;
        logic [3:0]  item_count;
    } result_t;

endpackage

// File: rtl/ampq_mem.sv
// Entry store: one write port, one read port with registered read data.
module ampq_mem
(
    input  logic              clk,
    input  logic              we,
    input  ampq_pkg::addr_t   waddr,
    input  ampq_pkg::entry_t  wdata,
    input  ampq_pkg::addr_t   raddr,
    output ampq_pkg::entry_t  rdata
);

    ampq_pkg::entry_t mem [ampq_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/array_max_priority_queue.sv
// Insert, empty/full reject and no-op report their result in the cycle after the start beat.
// Peek: the scan reads one entry per cycle, then SCAN_LAST does the last compare and reports.
// Delete: the same scan, then, if later entries exist, SHIFT moves each down one slot before reporting.
// Throughput: a new beat is taken in the cycle the result shows; one read port sets the pace.
// Reset (rst_n low, asynchronous) empties the queue; entry contents stay undefined until written.
// The receiver cannot stall: each result is shown for one cycle on done.
module array_max_priority_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ampq_pkg::cmd_t      cmd,
    output logic                busy,
    output logic                done,
    output ampq_pkg::result_t   result
);

`include "array_max_priority_queue_macros.svh"

    // Sequencer: scan issues one read per cycle; the last compare happens in
    // SCAN_LAST while no read is issued; SHIFT moves later entries down.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_LAST,
        S_SHIFT
    } state_t;

    state_t                        state_reg;
    ampq_pkg::cnt_t                cnt_reg;
    logic [1:0]                    op_reg;        // request being worked on
    ampq_pkg::addr_t               scan_idx_reg;  // address being read in the scan
    ampq_pkg::addr_t               cmp_idx_reg;   // address whose data is on rdata
    logic                          cmp_vld_reg;
    logic [ampq_pkg::PRIORITY_BITS-1:0] best_prio_reg;
    logic [ampq_pkg::VALUE_BITS-1:0]    best_val_reg;
    ampq_pkg::addr_t               best_slot_reg;
    ampq_pkg::cnt_t                sh_rd_reg;     // next source slot of the shift
    ampq_pkg::addr_t               wr_addr_reg;   // destination of the pending move
    logic                          wr_vld_reg;
    logic                          done_reg;
    ampq_pkg::result_t             result_reg;

    // Memory port signals
    logic                          mem_we;
    ampq_pkg::addr_t               mem_waddr;
    ampq_pkg::entry_t              mem_wdata;
    ampq_pkg::addr_t               mem_raddr;
    ampq_pkg::entry_t              mem_rdata;

    // Shared compare unit: first entry always wins, later only on strictly
    // greater priority, so ties keep the oldest.
    logic                          take_new;
    logic [ampq_pkg::PRIORITY_BITS-1:0] fin_prio;
    logic [ampq_pkg::VALUE_BITS-1:0]    fin_val;
    ampq_pkg::addr_t               fin_slot;
    ampq_pkg::cnt_t                cnt_m1;
    ampq_pkg::cnt_t                fin_slot_p1;
    logic                          accept;

    assign accept      = start && (state_reg == S_IDLE);
    assign cnt_m1      = cnt_reg - ampq_pkg::CNT_W'(1);
    assign take_new    = (cmp_idx_reg == '0) || (mem_rdata.prio > best_prio_reg);
    assign fin_prio    = take_new ? mem_rdata.prio  : best_prio_reg;
    assign fin_val     = take_new ? mem_rdata.value : best_val_reg;
    assign fin_slot    = take_new ? cmp_idx_reg     : best_slot_reg;
    assign fin_slot_p1 = ampq_pkg::CNT_W'(fin_slot) + ampq_pkg::CNT_W'(1);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ampq_pkg::addr_t'(cnt_reg);
        mem_wdata = mem_rdata;
        mem_raddr = scan_idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                // Append at the tail on an insert with room.
                mem_we    = accept && (cmd.req_type == ampq_pkg::REQ_INSERT)
                            && (cnt_reg < ampq_pkg::CNT_W'(ampq_pkg::CAPACITY));
                mem_wdata.value = ampq_pkg::VALUE_BITS'(cmd.in_element);
                mem_wdata.prio  = ampq_pkg::PRIORITY_BITS'(cmd.in_priority);
            end
            S_SHIFT:
            begin
                mem_we    = wr_vld_reg;
                mem_waddr = wr_addr_reg;
                mem_raddr = ampq_pkg::addr_t'(sh_rd_reg);
            end
            default:
            begin
            end
        endcase
    end

    ampq_mem u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            op_reg        <= ampq_pkg::REQ_INSERT;
            scan_idx_reg  <= '0;
            cmp_idx_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            best_prio_reg <= '0;
            best_val_reg  <= '0;
            best_slot_reg <= '0;
            sh_rd_reg     <= '0;
            wr_addr_reg   <= '0;
            wr_vld_reg    <= 1'b0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg       <= cmd.req_type;
                        scan_idx_reg <= '0;
                        cmp_vld_reg  <= 1'b0;
                        result_reg   <= '0;
                        priority case (1'b1)
                            (cmd.req_type == ampq_pkg::REQ_INSERT):
                            begin
                                done_reg <= 1'b1;
                                if (cnt_reg < ampq_pkg::CNT_W'(ampq_pkg::CAPACITY))
                                begin
                                    cnt_reg <= cnt_reg + ampq_pkg::CNT_W'(1);
                                    result_reg.status     <= ampq_pkg::ST_OK;
                                    result_reg.item_count <= 4'(cnt_reg + ampq_pkg::CNT_W'(1));
                                end
                                else
                                begin
                                    result_reg.status     <= ampq_pkg::ST_FULL;
                                    result_reg.item_count <= 4'(cnt_reg);
                                end
                            end
                            (cmd.req_type == ampq_pkg::REQ_DELETE ||
                             cmd.req_type == ampq_pkg::REQ_PEEK):
                            begin
                                if (cnt_reg == '0)
                                begin
                                    done_reg              <= 1'b1;
                                    result_reg.status     <= ampq_pkg::ST_EMPTY;
                                    result_reg.item_count <= 4'(cnt_reg);
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            default:
                            begin
                                // unused code: no-op
                                done_reg              <= 1'b1;
                                result_reg.status     <= ampq_pkg::ST_OK;
                                result_reg.item_count <= 4'(cnt_reg);
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (cmp_vld_reg)
                    begin
                        best_prio_reg <= fin_prio;
                        best_val_reg  <= fin_val;
                        best_slot_reg <= fin_slot;
                    end
                    cmp_vld_reg <= 1'b1;
                    cmp_idx_reg <= scan_idx_reg;
                    if (ampq_pkg::CNT_W'(scan_idx_reg) == cnt_m1)
                    begin
                        state_reg <= S_SCAN_LAST;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + ampq_pkg::ADDR_W'(1);
                    end
                end
                S_SCAN_LAST:
                begin
                    cmp_vld_reg <= 1'b0;
                    best_slot_reg <= fin_slot;
                    result_reg.out_priority <= 8'(fin_prio);
                    result_reg.status       <= ampq_pkg::ST_OK;
                    if (op_reg == ampq_pkg::REQ_DELETE)
                    begin
                        result_reg.out_element <= 16'(fin_val);
                        if (fin_slot_p1 < cnt_reg)
                        begin
                            sh_rd_reg  <= fin_slot_p1;
                            wr_vld_reg <= 1'b0;
                            state_reg  <= S_SHIFT;
                        end
                        else
                        begin
                            cnt_reg               <= cnt_m1;
                            result_reg.item_count <= 4'(cnt_m1);
                            done_reg              <= 1'b1;
                            state_reg             <= S_IDLE;
                        end
                    end
                    else
                    begin
                        result_reg.item_count <= 4'(cnt_reg);
                        done_reg              <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end
                S_SHIFT:
                begin
                    // Read slot sh_rd while the previous read lands one slot down.
                    if (sh_rd_reg < cnt_reg)
                    begin
                        wr_addr_reg <= ampq_pkg::addr_t'(sh_rd_reg - ampq_pkg::CNT_W'(1));
                        wr_vld_reg  <= 1'b1;
                        sh_rd_reg   <= sh_rd_reg + ampq_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        wr_vld_reg            <= 1'b0;
                        cnt_reg               <= cnt_m1;
                        result_reg.item_count <= 4'(cnt_m1);
                        done_reg              <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    `AMPQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= ampq_pkg::CNT_W'(ampq_pkg::CAPACITY), "count beyond capacity")
    `AMPQ_ASSERT_NOW(a_full_ok, done && (result.status == ampq_pkg::ST_FULL), cnt_reg == ampq_pkg::CNT_W'(ampq_pkg::CAPACITY), "full reported with room")
    `AMPQ_ASSERT_NEXT(a_start_resp, start && !busy, busy || done, "start beat left unanswered")
    `AMPQ_ASSERT_NOW(a_shift_addr, (state_reg == S_SHIFT) && wr_vld_reg, ampq_pkg::CNT_W'(wr_addr_reg) < cnt_m1, "shift write beyond new tail")

endmodule

// File: tb/sv/tb_array_max_priority_queue.sv
// Self-checking testbench of the array max-priority queue: driver, predictor and result checker.
module tb_array_max_priority_queue;

    timeunit 1ns;
    timeprecision 1ps;

    import ampq_pkg::*;

    // A command waiting to be driven; hold_for_drain makes the driver wait until
    // every result already owed has come back before offering this beat.
    typedef struct {
        cmd_t cmd;
        bit   hold_for_drain;
    } queued_cmd_t;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd   = '0;
    logic    busy;
    logic    done;
    result_t result;

    queued_cmd_t cmd_backlog[$];
    result_t     expected_results[$];

    // Own copy of the queue contents, kept in arrival order as the block keeps it.
    logic [VALUE_BITS-1:0]    held_value [CAPACITY];
    logic [PRIORITY_BITS-1:0] held_prio  [CAPACITY];
    int                       held_count;

    int  error_count;
    int  beats_sent;
    // Set at the rising edge that took a start beat; the driver reads it on the falling edge.
    logic beat_taken = 1'b0;

    array_max_priority_queue dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the result of one request and moves the held state on.
    // Delete and peek pick the oldest entry carrying the highest priority:
    // the strict greater-than keeps the first of any tie.
    function automatic result_t serve_request(cmd_t c);
        result_t r;
        int      best;
        r        = '0;
        r.status = ST_OK;
        case (c.req_type)
            REQ_INSERT:
            begin
                if (held_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    held_value[held_count] = c.in_element;
                    held_prio[held_count]  = c.in_priority;
                    held_count++;
                end
            end
            REQ_DELETE, REQ_PEEK:
            begin
                if (held_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    best = 0;
                    for (int i = 1; i < held_count; i++)
                        if (held_prio[i] > held_prio[best])
                            best = i;
                    r.out_priority = held_prio[best];
                    if (c.req_type == REQ_DELETE)
                    begin
                        r.out_element = held_value[best];
                        // close the gap: later entries move down one slot
                        for (int j = best; j + 1 < held_count; j++)
                        begin
                            held_value[j] = held_value[j + 1];
                            held_prio[j]  = held_prio[j + 1];
                        end
                        held_count--;
                    end
                end
            end
            default: ; // code three: nothing happens, the count is still reported
        endcase
        r.item_count = 4'(held_count);
        return r;
    endfunction

    task automatic check_field(string field, int unsigned exp_v, logic [15:0] act_v);
        if (act_v !== 16'(exp_v))
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
            error_count++;
        end
    endtask

    // Rising edge: note accepted beats (and predict them), check any result shown.
    // The result is checked before the new beat is predicted, though both only
    // touch opposite ends of the expectation queue.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none expected, actual %p", $time, result);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("out_element",  want.out_element,  result.out_element);
                    check_field("out_priority", want.out_priority, 16'(result.out_priority));
                    check_field("status",       want.status,       16'(result.status));
                    check_field("item_count",   want.item_count,   16'(result.item_count));
                end
            end
            if (start && !busy)
                expected_results.push_back(serve_request(cmd));
            beat_taken <= start && !busy;
        end
    end

    // Falling edge: retire the beat just taken and choose what to offer next.
    // One assignment per signal per edge.
    always @(negedge clk)
    begin
        logic next_start;
        cmd_t next_cmd;
        next_start = 1'b0;
        next_cmd   = cmd;
        if (rst_n)
        begin
            if (beat_taken && cmd_backlog.size() != 0)
            begin
                void'(cmd_backlog.pop_front());
                beats_sent++;
            end
            if (cmd_backlog.size() != 0)
            begin
                // idle on about 9 rolls in a hundred, none through the quiet stretch
                if (!(beats_sent >= 400 && beats_sent < 700) && $urandom_range(99) < 9)
                    next_start = 1'b0;
                else if (cmd_backlog[0].hold_for_drain && expected_results.size() != 0)
                    next_start = 1'b0;
                else
                begin
                    next_start = 1'b1;
                    next_cmd   = cmd_backlog[0].cmd;
                end
            end
        end
        start <= next_start;
        cmd   <= next_cmd;
    end

    task automatic queue_cmd(logic [1:0] req, logic [15:0] elem, logic [7:0] prio,
                             bit drain = 1'b0);
        queued_cmd_t q;
        q.cmd.req_type    = req;
        q.cmd.in_element  = elem;
        q.cmd.in_priority = prio;
        q.hold_for_drain  = drain;
        cmd_backlog.push_back(q);
    endtask

    initial
    begin
        int          roll;
        logic [1:0]  req;
        logic [7:0]  prio;
        error_count = 0;
        beats_sent  = 0;
        held_count  = 0;

        // Directed beats: empty queue, extremes, ties, full queue, code three,
        // then empty it again one delete at a time.
        queue_cmd(REQ_PEEK,   16'($urandom), 8'($urandom));
        queue_cmd(REQ_DELETE, 16'($urandom), 8'($urandom));
        queue_cmd(REQ_NOP,    16'hFFFF,      8'hFF);
        queue_cmd(REQ_INSERT, 16'h0000, 8'h00);
        queue_cmd(REQ_INSERT, 16'hFFFF, 8'hFF);
        queue_cmd(REQ_INSERT, 16'h1234, 8'hFF);   // tie with the one before
        queue_cmd(REQ_INSERT, 16'hAAAA, 8'h80);
        queue_cmd(REQ_INSERT, 16'h5555, 8'h7F);
        queue_cmd(REQ_INSERT, 16'h0001, 8'h01);
        queue_cmd(REQ_INSERT, 16'h8000, 8'hFE);
        queue_cmd(REQ_INSERT, 16'h7FFF, 8'hFF);   // fills the queue
        queue_cmd(REQ_INSERT, 16'hBEEF, 8'h10);   // rejected, full
        queue_cmd(REQ_PEEK,   16'h0000, 8'h00);
        queue_cmd(REQ_NOP,    16'h0000, 8'h00);
        for (int i = 0; i < 9; i++)               // last one finds it empty
            queue_cmd(REQ_DELETE, 16'($urandom), 8'($urandom));

        // Random beats in 40-beat phases: filling, draining, mixed; narrow
        // priority ranges every other hundred beats so ties are common.
        for (int i = 0; i < 1500; i++)
        begin
            roll = $urandom_range(99);
            case ((i / 40) % 3)
                0:       req = (roll < 70) ? REQ_INSERT : (roll < 90) ? REQ_DELETE :
                               (roll < 97) ? REQ_PEEK : REQ_NOP;
                1:       req = (roll < 25) ? REQ_INSERT : (roll < 85) ? REQ_DELETE :
                               (roll < 97) ? REQ_PEEK : REQ_NOP;
                default: req = (roll < 45) ? REQ_INSERT : (roll < 80) ? REQ_DELETE :
                               (roll < 96) ? REQ_PEEK : REQ_NOP;
            endcase
            prio = ((i / 100) % 2) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
            queue_cmd(req, 16'($urandom), prio, (i == 750));
        end

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // All beats taken, then every owed result back, then a margin past the
        // longest delete to catch a stray result.
        while (cmd_backlog.size() != 0 || expected_results.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
